// File: src/sts_pkg.sv
// ============================================================================
// sts_pkg
// Shared types, constants and byte class functions of the S-expression
// token scanner.
// ============================================================================
package sts_pkg;

    localparam int POS_WIDTH      = 16;
    localparam int MANTISSA_WIDTH = 48;
    localparam int MAG_WIDTH      = MANTISSA_WIDTH - 1;
    localparam int FRAC_WIDTH     = 4;
    localparam int KIND_WIDTH     = 3;
    localparam int QUEUE_DEPTH    = 8;
    localparam int QUEUE_AW       = 3;

    localparam logic [POS_WIDTH-1:0] POS_MAX = {POS_WIDTH{1'b1}};
    localparam logic [MAG_WIDTH-1:0] MAG_MAX = {MAG_WIDTH{1'b1}};
    localparam logic [FRAC_WIDTH-1:0] MAX_FRAC = 4'd15;

    localparam logic [KIND_WIDTH-1:0] KIND_END    = 3'd0;
    localparam logic [KIND_WIDTH-1:0] KIND_LPAREN = 3'd1;
    localparam logic [KIND_WIDTH-1:0] KIND_RPAREN = 3'd2;
    localparam logic [KIND_WIDTH-1:0] KIND_STRING = 3'd3;
    localparam logic [KIND_WIDTH-1:0] KIND_SYMBOL = 3'd4;
    localparam logic [KIND_WIDTH-1:0] KIND_NUMBER = 3'd5;
    localparam logic [KIND_WIDTH-1:0] KIND_ERROR  = 3'd6;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_Z   = 8'h5A;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_Z   = 8'h7A;

    typedef enum logic [5:0] {
        MODE_IDLE   = 6'b000001,
        MODE_PEND   = 6'b000010,
        MODE_STRING = 6'b000100,
        MODE_SYMBOL = 6'b001000,
        MODE_INT    = 6'b010000,
        MODE_FRAC   = 6'b100000
    } t_mode;

    typedef struct packed {
        logic [KIND_WIDTH-1:0]            kind;
        logic [POS_WIDTH-1:0]             line;
        logic [POS_WIDTH-1:0]             column;
        logic [POS_WIDTH-1:0]             offset;
        logic [POS_WIDTH-1:0]             length;
        logic signed [MANTISSA_WIDTH-1:0] mantissa;
        logic [FRAC_WIDTH-1:0]            frac;
        logic                             last;
    } t_token;

    function automatic logic [POS_WIDTH-1:0] sat_inc(input logic [POS_WIDTH-1:0] v);
        return (v == POS_MAX) ? POS_MAX : v + 1'b1;
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= CH_ZERO) && (b <= CH_NINE);
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_CR) || (b == CH_LF);
    endfunction

    function automatic logic is_sym_start(input logic [7:0] b);
        return ((b >= CH_LO_A) && (b <= CH_LO_Z)) || ((b >= CH_UP_A) && (b <= CH_UP_Z)) ||
               (b == CH_UNDER) || (b == CH_COLON) || (b == CH_SLASH);
    endfunction

    function automatic logic is_sym_body(input logic [7:0] b);
        return is_sym_start(b) || is_digit(b) || (b == CH_MINUS) || (b == CH_DOT);
    endfunction

endpackage

// File: src/sexpr_token_scanner_top.sv
// ============================================================================
// sexpr_token_scanner_top
// Streaming S-expression tokenizer: one text byte in, zero to two tokens out.
// ============================================================================
// The input channel carries one text byte per transaction; a zero byte ends
// the text, flushes any open token, emits the end token and returns the
// scanner to line 1, column 1, offset 0. The output channel carries one token
// per transaction, each field on a port of its own; o_last_of_run marks the
// final token caused by a byte.
// An accepted byte is held in an input register and scanned in the next
// cycle; its tokens are written into an eight-entry token queue, whose
// oldest entry is presented on the output ports. One byte is accepted every
// cycle while the input is not stalled; a byte that yields two tokens needs
// two output transactions, which the queue absorbs. The input stalls when the
// queue could not hold the worst case of two tokens for both the byte in the
// input register and a newly accepted byte, so a stalled receiver backs up
// into the input. Tokens wait in the queue for as long as the receiver
// stalls; none is lost. Synchronous reset empties the queue and the input
// register and sets the scanner to its start-of-text state.
// ============================================================================
module sexpr_token_scanner_top (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_in_valid,
    output logic                                    o_in_stall,
    input  logic [7:0]                              i_in_byte,
    output logic                                    o_out_valid,
    input  logic                                    i_out_stall,
    output logic [sts_pkg::KIND_WIDTH-1:0]          o_token_kind,
    output logic [sts_pkg::POS_WIDTH-1:0]           o_token_line,
    output logic [sts_pkg::POS_WIDTH-1:0]           o_token_column,
    output logic [sts_pkg::POS_WIDTH-1:0]           o_token_offset,
    output logic [sts_pkg::POS_WIDTH-1:0]           o_token_length,
    output logic signed [sts_pkg::MANTISSA_WIDTH-1:0] o_num_mantissa,
    output logic [sts_pkg::FRAC_WIDTH-1:0]          o_frac_digits,
    output logic                                    o_last_of_run
);

    localparam int PW = sts_pkg::POS_WIDTH;
    localparam int MW = sts_pkg::MAG_WIDTH;
    localparam int FW = sts_pkg::FRAC_WIDTH;

    logic                   r_in_valid;
    logic [7:0]             r_in_byte;

    sts_pkg::t_mode         r_mode, n_mode;
    logic [PW-1:0]          r_cur_line, n_cur_line;
    logic [PW-1:0]          r_cur_column, n_cur_column;
    logic [PW-1:0]          r_cur_offset, n_cur_offset;
    logic [PW-1:0]          r_start_line, n_start_line;
    logic [PW-1:0]          r_start_column, n_start_column;
    logic [PW-1:0]          r_start_offset, n_start_offset;
    logic [PW-1:0]          r_run_length, n_run_length;
    logic [MW-1:0]          r_mant, n_mant;
    logic [FW-1:0]          r_frac, n_frac;
    logic                   r_neg, n_neg;
    logic                   r_pend_minus, n_pend_minus;
    logic                   r_escape, n_escape;

    sts_pkg::t_token        r_queue [sts_pkg::QUEUE_DEPTH];
    logic [sts_pkg::QUEUE_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [sts_pkg::QUEUE_AW:0]   r_count;

    logic                   in_accept;
    logic                   out_pop;
    logic [7:0]             b;
    logic [MW+3:0]          mac_sum;
    logic [MW-1:0]          mac_sat;
    logic [MW:0]            mant_ext;
    logic [MW:0]            mant_signed;
    logic                   flush_v;
    logic [sts_pkg::KIND_WIDTH-1:0] flush_kind;
    logic                   do_tail;
    logic                   do_adv;
    logic                   tail_v;
    sts_pkg::t_token        flush_tok, tail_tok, slot0, slot1;
    logic                   slot0_v, slot1_v;
    logic [1:0]             push_cnt;

    assign b         = r_in_byte;
    assign out_pop   = o_out_valid && !i_out_stall;
    assign in_accept = i_in_valid && !o_in_stall;

    assign o_in_stall = ({1'b0, r_count} + {3'b000, r_in_valid, 1'b0})
                        > (sts_pkg::QUEUE_AW + 2)'(sts_pkg::QUEUE_DEPTH - 2);

    assign mac_sum = {1'b0, r_mant, 3'b000} + {3'b000, r_mant, 1'b0}
                     + {{MW{1'b0}}, b[3:0]};
    assign mac_sat = (mac_sum > {4'b0000, sts_pkg::MAG_MAX}) ? sts_pkg::MAG_MAX
                                                              : mac_sum[MW-1:0];

    assign mant_ext    = {1'b0, r_mant};
    assign mant_signed = r_neg ? ((MW + 1)'(0) - mant_ext) : mant_ext;

    always_comb begin
        n_mode         = r_mode;
        n_cur_line     = r_cur_line;
        n_cur_column   = r_cur_column;
        n_cur_offset   = r_cur_offset;
        n_start_line   = r_start_line;
        n_start_column = r_start_column;
        n_start_offset = r_start_offset;
        n_run_length   = r_run_length;
        n_mant         = r_mant;
        n_frac         = r_frac;
        n_neg          = r_neg;
        n_pend_minus   = r_pend_minus;
        n_escape       = r_escape;
        flush_v        = 1'b0;
        flush_kind     = sts_pkg::KIND_ERROR;
        do_tail        = 1'b0;
        do_adv         = 1'b0;
        tail_v         = 1'b0;
        tail_tok       = '0;
        tail_tok.last  = 1'b1;

        case (r_mode)
            sts_pkg::MODE_PEND: begin
                if (sts_pkg::is_digit(b)) begin
                    n_neg        = r_pend_minus;
                    n_mant       = {{(MW - 4){1'b0}}, b[3:0]};
                    n_frac       = r_pend_minus ? FW'(0) : FW'(1);
                    n_run_length = sts_pkg::sat_inc(r_run_length);
                    n_mode       = r_pend_minus ? sts_pkg::MODE_INT : sts_pkg::MODE_FRAC;
                    do_adv       = 1'b1;
                end else begin
                    flush_v    = 1'b1;
                    flush_kind = sts_pkg::KIND_ERROR;
                    n_mode     = sts_pkg::MODE_IDLE;
                    do_tail    = 1'b1;
                end
            end
            sts_pkg::MODE_STRING: begin
                if (b == sts_pkg::CH_NUL) begin
                    flush_v    = 1'b1;
                    flush_kind = sts_pkg::KIND_ERROR;
                    n_mode     = sts_pkg::MODE_IDLE;
                    do_tail    = 1'b1;
                end else if ((b == sts_pkg::CH_QUOTE) && !r_escape) begin
                    flush_v    = 1'b1;
                    flush_kind = sts_pkg::KIND_STRING;
                    n_mode     = sts_pkg::MODE_IDLE;
                    do_adv     = 1'b1;
                end else begin
                    n_run_length = sts_pkg::sat_inc(r_run_length);
                    n_escape     = (b == sts_pkg::CH_BSLASH);
                    do_adv       = 1'b1;
                end
            end
            sts_pkg::MODE_SYMBOL: begin
                if (sts_pkg::is_sym_body(b)) begin
                    n_run_length = sts_pkg::sat_inc(r_run_length);
                    do_adv       = 1'b1;
                end else begin
                    flush_v    = 1'b1;
                    flush_kind = sts_pkg::KIND_SYMBOL;
                    n_mode     = sts_pkg::MODE_IDLE;
                    do_tail    = 1'b1;
                end
            end
            sts_pkg::MODE_INT, sts_pkg::MODE_FRAC: begin
                if (sts_pkg::is_digit(b)) begin
                    if (r_mode == sts_pkg::MODE_INT) begin
                        n_mant = mac_sat;
                    end else if (r_frac < sts_pkg::MAX_FRAC) begin
                        n_mant = mac_sat;
                        n_frac = r_frac + 1'b1;
                    end
                    n_run_length = sts_pkg::sat_inc(r_run_length);
                    do_adv       = 1'b1;
                end else if ((b == sts_pkg::CH_DOT) && (r_mode == sts_pkg::MODE_INT)) begin
                    n_mode       = sts_pkg::MODE_FRAC;
                    n_run_length = sts_pkg::sat_inc(r_run_length);
                    do_adv       = 1'b1;
                end else begin
                    flush_v    = 1'b1;
                    flush_kind = sts_pkg::KIND_NUMBER;
                    n_mode     = sts_pkg::MODE_IDLE;
                    do_tail    = 1'b1;
                end
            end
            default: begin
                n_mode  = sts_pkg::MODE_IDLE;
                do_tail = 1'b1;
            end
        endcase

        if (do_tail) begin
            if (b == sts_pkg::CH_NUL) begin
                tail_v          = 1'b1;
                tail_tok.kind   = sts_pkg::KIND_END;
                tail_tok.line   = r_cur_line;
                tail_tok.column = r_cur_column;
                tail_tok.offset = r_cur_offset;
                n_mode          = sts_pkg::MODE_IDLE;
                n_cur_line      = PW'(1);
                n_cur_column    = PW'(1);
                n_cur_offset    = '0;
                n_start_line    = PW'(1);
                n_start_column  = PW'(1);
                n_start_offset  = '0;
                n_run_length    = '0;
                n_mant          = '0;
                n_frac          = '0;
                n_neg           = 1'b0;
                n_pend_minus    = 1'b0;
                n_escape        = 1'b0;
            end else begin
                do_adv = 1'b1;
                tail_tok.line   = r_cur_line;
                tail_tok.column = r_cur_column;
                tail_tok.offset = r_cur_offset;
                tail_tok.length = PW'(1);
                if (sts_pkg::is_space(b)) begin
                    tail_v = 1'b0;
                end else if ((b == sts_pkg::CH_LPAREN) || (b == sts_pkg::CH_RPAREN)) begin
                    tail_v        = 1'b1;
                    tail_tok.kind = (b == sts_pkg::CH_LPAREN) ? sts_pkg::KIND_LPAREN
                                                              : sts_pkg::KIND_RPAREN;
                end else if (b == sts_pkg::CH_QUOTE) begin
                    n_start_line   = r_cur_line;
                    n_start_column = r_cur_column;
                    n_start_offset = sts_pkg::sat_inc(r_cur_offset);
                    n_run_length   = '0;
                    n_escape       = 1'b0;
                    n_mode         = sts_pkg::MODE_STRING;
                end else begin
                    n_start_line   = r_cur_line;
                    n_start_column = r_cur_column;
                    n_start_offset = r_cur_offset;
                    n_run_length   = PW'(1);
                    if (sts_pkg::is_digit(b)) begin
                        n_mant = {{(MW - 4){1'b0}}, b[3:0]};
                        n_frac = '0;
                        n_neg  = 1'b0;
                        n_mode = sts_pkg::MODE_INT;
                    end else if ((b == sts_pkg::CH_MINUS) || (b == sts_pkg::CH_DOT)) begin
                        n_pend_minus = (b == sts_pkg::CH_MINUS);
                        n_mode       = sts_pkg::MODE_PEND;
                    end else if (sts_pkg::is_sym_start(b)) begin
                        n_mode = sts_pkg::MODE_SYMBOL;
                    end else begin
                        tail_v        = 1'b1;
                        tail_tok.kind = sts_pkg::KIND_ERROR;
                    end
                end
            end
        end

        if (do_adv) begin
            if (b == sts_pkg::CH_LF) begin
                n_cur_line   = sts_pkg::sat_inc(r_cur_line);
                n_cur_column = PW'(1);
            end else begin
                n_cur_column = sts_pkg::sat_inc(r_cur_column);
            end
            n_cur_offset = sts_pkg::sat_inc(r_cur_offset);
        end
    end

    always_comb begin
        flush_tok.kind     = flush_kind;
        flush_tok.line     = r_start_line;
        flush_tok.column   = r_start_column;
        flush_tok.offset   = r_start_offset;
        flush_tok.length   = r_run_length;
        flush_tok.mantissa = (flush_kind == sts_pkg::KIND_NUMBER) ? mant_signed : '0;
        flush_tok.frac     = (flush_kind == sts_pkg::KIND_NUMBER) ? r_frac : '0;
        flush_tok.last     = !tail_v;

        slot0   = flush_v ? flush_tok : tail_tok;
        slot1   = tail_tok;
        slot0_v = r_in_valid && (flush_v || tail_v);
        slot1_v = r_in_valid && flush_v && tail_v;
        push_cnt = {1'b0, slot0_v} + {1'b0, slot1_v};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid     <= 1'b0;
            r_in_byte      <= '0;
            r_mode         <= sts_pkg::MODE_IDLE;
            r_cur_line     <= PW'(1);
            r_cur_column   <= PW'(1);
            r_cur_offset   <= '0;
            r_start_line   <= PW'(1);
            r_start_column <= PW'(1);
            r_start_offset <= '0;
            r_run_length   <= '0;
            r_mant         <= '0;
            r_frac         <= '0;
            r_neg          <= 1'b0;
            r_pend_minus   <= 1'b0;
            r_escape       <= 1'b0;
            r_wr_ptr       <= '0;
            r_rd_ptr       <= '0;
            r_count        <= '0;
        end else begin
            r_in_valid <= in_accept;
            if (in_accept) begin
                r_in_byte <= i_in_byte;
            end
            if (r_in_valid) begin
                r_mode         <= n_mode;
                r_cur_line     <= n_cur_line;
                r_cur_column   <= n_cur_column;
                r_cur_offset   <= n_cur_offset;
                r_start_line   <= n_start_line;
                r_start_column <= n_start_column;
                r_start_offset <= n_start_offset;
                r_run_length   <= n_run_length;
                r_mant         <= n_mant;
                r_frac         <= n_frac;
                r_neg          <= n_neg;
                r_pend_minus   <= n_pend_minus;
                r_escape       <= n_escape;
            end
            r_wr_ptr <= r_wr_ptr + sts_pkg::QUEUE_AW'(push_cnt);
            if (out_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + (sts_pkg::QUEUE_AW + 1)'(push_cnt)
                       - (sts_pkg::QUEUE_AW + 1)'(out_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (slot0_v) begin
            r_queue[r_wr_ptr] <= slot0;
        end
        if (slot1_v) begin
            r_queue[r_wr_ptr + 1'b1] <= slot1;
        end
    end

    assign o_out_valid    = (r_count != '0);
    assign o_token_kind   = r_queue[r_rd_ptr].kind;
    assign o_token_line   = r_queue[r_rd_ptr].line;
    assign o_token_column = r_queue[r_rd_ptr].column;
    assign o_token_offset = r_queue[r_rd_ptr].offset;
    assign o_token_length = r_queue[r_rd_ptr].length;
    assign o_num_mantissa = r_queue[r_rd_ptr].mantissa;
    assign o_frac_digits  = r_queue[r_rd_ptr].frac;
    assign o_last_of_run  = r_queue[r_rd_ptr].last;

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Self-checking bench for the S-expression token scanner.
// Two short directed texts and about nineteen hundred bytes of random texts are
// streamed in. Both channels idle in random bursts, except in the last part
// of the run. A scoreboard predicts every token and compares each received
// token field by field against the oldest prediction.
// ============================================================================

import sts_pkg::*;

class token_checker;
    typedef enum {
        CC_BLANK, CC_DIGIT, CC_SIGN, CC_NAME, CC_OPEN, CC_CLOSE, CC_QUOTE, CC_NUL, CC_OTHER
    } t_char_class;

    t_mode                      mode;
    logic [POS_WIDTH-1:0]       cur_ln;
    logic [POS_WIDTH-1:0]       cur_col;
    logic [POS_WIDTH-1:0]       cur_off;
    logic [POS_WIDTH-1:0]       tok_ln;
    logic [POS_WIDTH-1:0]       tok_col;
    logic [POS_WIDTH-1:0]       tok_off;
    logic [POS_WIDTH-1:0]       tok_len;
    logic [MAG_WIDTH-1:0]       mag;
    logic [FRAC_WIDTH-1:0]      nfrac;
    logic                       neg;
    logic [7:0]                 held;
    logic                       escaped;

    t_token                     tokens_due[$];
    t_token                     burst[$];
    int                         errors;
    int                         reports;
    int                         bytes_in;
    int                         texts_done;
    int                         kind_count[7];

    function new();
        errors = 0;
        reports = 0;
        bytes_in = 0;
        texts_done = 0;
        foreach (kind_count[i]) kind_count[i] = 0;
        restart();
    endfunction

    function void restart();
        mode = MODE_IDLE;
        cur_ln = 1;
        cur_col = 1;
        cur_off = 0;
        tok_ln = 1;
        tok_col = 1;
        tok_off = 0;
        tok_len = 0;
        mag = '0;
        nfrac = '0;
        neg = 1'b0;
        held = 8'h00;
        escaped = 1'b0;
    endfunction

    function t_char_class classify(logic [7:0] b);
        if (b == CH_NUL) return CC_NUL;
        if (b == CH_SPACE || b == CH_TAB || b == CH_CR || b == CH_LF) return CC_BLANK;
        if (b >= CH_ZERO && b <= CH_NINE) return CC_DIGIT;
        if (b == CH_MINUS || b == CH_DOT) return CC_SIGN;
        if ((b >= CH_LO_A && b <= CH_LO_Z) || (b >= CH_UP_A && b <= CH_UP_Z) ||
            b == CH_UNDER || b == CH_COLON || b == CH_SLASH) return CC_NAME;
        if (b == CH_LPAREN) return CC_OPEN;
        if (b == CH_RPAREN) return CC_CLOSE;
        if (b == CH_QUOTE) return CC_QUOTE;
        return CC_OTHER;
    endfunction

    function logic [POS_WIDTH-1:0] pos_inc(logic [POS_WIDTH-1:0] v);
        return (v == POS_MAX) ? v : v + 1'b1;
    endfunction

    function logic [MAG_WIDTH-1:0] mag_push(logic [MAG_WIDTH-1:0] m, logic [3:0] d);
        longint unsigned wide;
        wide = 64'(m) * 64'd10 + 64'(d);
        return (wide > 64'(MAG_MAX)) ? MAG_MAX : wide[MAG_WIDTH-1:0];
    endfunction

    function void emit(input logic [KIND_WIDTH-1:0] kind,
                       input logic [POS_WIDTH-1:0] ln, col, off, len,
                       input logic signed [MANTISSA_WIDTH-1:0] mant,
                       input logic [FRAC_WIDTH-1:0] frac);
        t_token t;
        t.kind = kind;
        t.line = ln;
        t.column = col;
        t.offset = off;
        t.length = len;
        t.mantissa = mant;
        t.frac = frac;
        t.last = 1'b0;
        burst.push_back(t);
    endfunction

    function void emit_run(logic [KIND_WIDTH-1:0] kind);
        emit(kind, tok_ln, tok_col, tok_off, tok_len, '0, '0);
    endfunction

    function void emit_number();
        logic signed [MANTISSA_WIDTH-1:0] m;
        m = {1'b0, mag};
        if (neg) m = -m;
        emit(KIND_NUMBER, tok_ln, tok_col, tok_off, tok_len, m, nfrac);
    endfunction

    function void step_position(logic [7:0] b);
        if (b == CH_LF) begin
            cur_ln = pos_inc(cur_ln);
            cur_col = 1;
        end else begin
            cur_col = pos_inc(cur_col);
        end
        cur_off = pos_inc(cur_off);
    endfunction

    function void grow(logic [7:0] b);
        tok_len = pos_inc(tok_len);
        step_position(b);
    endfunction

    function void open_token(logic [7:0] b);
        t_char_class cc;
        cc = classify(b);
        case (cc)
            CC_BLANK: ;
            CC_OPEN: emit(KIND_LPAREN, cur_ln, cur_col, cur_off, 1, '0, '0);
            CC_CLOSE: emit(KIND_RPAREN, cur_ln, cur_col, cur_off, 1, '0, '0);
            CC_QUOTE: begin
                tok_ln = cur_ln;
                tok_col = cur_col;
                tok_off = pos_inc(cur_off);
                tok_len = 0;
                escaped = 1'b0;
                mode = MODE_STRING;
            end
            default: begin
                tok_ln = cur_ln;
                tok_col = cur_col;
                tok_off = cur_off;
                tok_len = 1;
                if (cc == CC_DIGIT) begin
                    mag = b - CH_ZERO;
                    nfrac = '0;
                    neg = 1'b0;
                    mode = MODE_INT;
                end else if (cc == CC_SIGN) begin
                    held = b;
                    mode = MODE_PEND;
                end else if (cc == CC_NAME) begin
                    mode = MODE_SYMBOL;
                end else begin
                    emit_run(KIND_ERROR);
                end
            end
        endcase
    endfunction

    function void scan_byte(logic [7:0] b);
        t_char_class cc;
        bit consumed;
        cc = classify(b);
        consumed = 1'b0;
        burst.delete();
        bytes_in++;
        case (mode)
            MODE_PEND: begin
                if (cc == CC_DIGIT) begin
                    neg = (held == CH_MINUS);
                    mag = b - CH_ZERO;
                    if (neg) begin
                        nfrac = 4'd0;
                        mode = MODE_INT;
                    end else begin
                        nfrac = 4'd1;
                        mode = MODE_FRAC;
                    end
                    grow(b);
                    consumed = 1'b1;
                end else begin
                    emit_run(KIND_ERROR);
                    mode = MODE_IDLE;
                end
            end
            MODE_STRING: begin
                if (cc == CC_NUL) begin
                    emit_run(KIND_ERROR);
                    mode = MODE_IDLE;
                end else begin
                    if (cc == CC_QUOTE && !escaped) begin
                        emit_run(KIND_STRING);
                        mode = MODE_IDLE;
                    end else begin
                        tok_len = pos_inc(tok_len);
                        escaped = (b == CH_BSLASH);
                    end
                    step_position(b);
                    consumed = 1'b1;
                end
            end
            MODE_SYMBOL: begin
                if (cc == CC_NAME || cc == CC_DIGIT || cc == CC_SIGN) begin
                    grow(b);
                    consumed = 1'b1;
                end else begin
                    emit_run(KIND_SYMBOL);
                    mode = MODE_IDLE;
                end
            end
            MODE_INT, MODE_FRAC: begin
                if (cc == CC_DIGIT) begin
                    if (mode == MODE_INT) begin
                        mag = mag_push(mag, 4'(b - CH_ZERO));
                    end else if (nfrac < MAX_FRAC) begin
                        mag = mag_push(mag, 4'(b - CH_ZERO));
                        nfrac++;
                    end
                    grow(b);
                    consumed = 1'b1;
                end else if (b == CH_DOT && mode == MODE_INT) begin
                    mode = MODE_FRAC;
                    grow(b);
                    consumed = 1'b1;
                end else begin
                    emit_number();
                    mode = MODE_IDLE;
                end
            end
            default: mode = MODE_IDLE;
        endcase
        if (!consumed) begin
            if (cc == CC_NUL) begin
                emit(KIND_END, cur_ln, cur_col, cur_off, 0, '0, '0);
                restart();
                texts_done++;
            end else begin
                open_token(b);
                step_position(b);
            end
        end
        if (burst.size() > 0) burst[burst.size() - 1].last = 1'b1;
        foreach (burst[i]) tokens_due.push_back(burst[i]);
    endfunction

    function void flag(string field, longint want_v, longint got_v);
        errors++;
        if (reports < 40)
            $display("time %0t: %s mismatch, expected %0d, actual %0d",
                     $time, field, want_v, got_v);
        reports++;
    endfunction

    function void match_token(t_token got);
        t_token want;
        if (tokens_due.size() == 0) begin
            errors++;
            if (reports < 40)
                $display("time %0t: token kind %0d at line %0d column %0d with none expected",
                         $time, got.kind, got.line, got.column);
            reports++;
            return;
        end
        want = tokens_due.pop_front();
        kind_count[want.kind]++;
        if (got.kind !== want.kind) flag("kind", want.kind, got.kind);
        if (got.line !== want.line) flag("line", want.line, got.line);
        if (got.column !== want.column) flag("column", want.column, got.column);
        if (got.offset !== want.offset) flag("offset", want.offset, got.offset);
        if (got.length !== want.length) flag("length", want.length, got.length);
        if (got.mantissa !== want.mantissa)
            flag("mantissa", longint'($signed(want.mantissa)), longint'($signed(got.mantissa)));
        if (got.frac !== want.frac) flag("fraction digits", want.frac, got.frac);
        if (got.last !== want.last) flag("last of run", want.last, got.last);
    endfunction

    function void leftover();
        if (tokens_due.size() > 0) begin
            errors++;
            $display("time %0t: %0d expected tokens never arrived, first of kind %0d",
                     $time, tokens_due.size(), tokens_due[0].kind);
        end
    endfunction
endclass

module testbench;
    localparam string NAME_HEAD = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_:/";
    localparam string NAME_BODY =
        "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_:/0123456789-.";

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             i_in_valid = 1'b0;
    logic [7:0]                       i_in_byte = 8'h00;
    logic                             i_out_stall = 1'b0;
    logic                             o_in_stall;
    logic                             o_out_valid;
    logic [KIND_WIDTH-1:0]            o_token_kind;
    logic [POS_WIDTH-1:0]             o_token_line;
    logic [POS_WIDTH-1:0]             o_token_column;
    logic [POS_WIDTH-1:0]             o_token_offset;
    logic [POS_WIDTH-1:0]             o_token_length;
    logic signed [MANTISSA_WIDTH-1:0] o_num_mantissa;
    logic [FRAC_WIDTH-1:0]            o_frac_digits;
    logic                             o_last_of_run;

    int           gap_pct = 0;
    int           stall_pct = 0;
    int           stall_left = 0;
    int           sent_bytes = 0;
    logic [7:0]   text_q[$];
    token_checker sb;
    t_token       seen_tok;

    sexpr_token_scanner_top u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_in_byte      (i_in_byte),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_token_kind   (o_token_kind),
        .o_token_line   (o_token_line),
        .o_token_column (o_token_column),
        .o_token_offset (o_token_offset),
        .o_token_length (o_token_length),
        .o_num_mantissa (o_num_mantissa),
        .o_frac_digits  (o_frac_digits),
        .o_last_of_run  (o_last_of_run)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) sb.scan_byte(i_in_byte);
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            seen_tok = {o_token_kind, o_token_line, o_token_column, o_token_offset,
                        o_token_length, o_num_mantissa, o_frac_digits, o_last_of_run};
            sb.match_token(seen_tok);
        end
    end

    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            i_out_stall <= 1'b1;
        end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
            stall_left = $urandom_range(0, 8);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    function automatic logic [7:0] pick(string set);
        return set[$urandom_range(0, set.len() - 1)];
    endfunction

    function automatic logic [7:0] any_digit();
        return 8'(CH_ZERO + $urandom_range(0, 9));
    endfunction

    function automatic void add_number();
        int whole;
        int part;
        if ($urandom_range(0, 2) == 0) text_q.push_back(CH_MINUS);
        if ($urandom_range(0, 9) == 0) whole = $urandom_range(14, 22);
        else if ($urandom_range(0, 5) == 0) whole = 0;
        else whole = $urandom_range(1, 5);
        repeat (whole) text_q.push_back(any_digit());
        if (whole == 0 || $urandom_range(0, 1) == 1) begin
            text_q.push_back(CH_DOT);
            if ($urandom_range(0, 7) == 0) part = $urandom_range(14, 20);
            else part = $urandom_range(whole == 0 ? 1 : 0, 4);
            repeat (part) text_q.push_back(any_digit());
        end
    endfunction

    function automatic void add_string(bit closed);
        logic [7:0] b;
        text_q.push_back(CH_QUOTE);
        repeat ($urandom_range(0, 10)) begin
            case ($urandom_range(0, 9))
                0: begin
                    text_q.push_back(CH_BSLASH);
                    text_q.push_back(CH_QUOTE);
                end
                1: text_q.push_back(CH_LF);
                2: begin
                    text_q.push_back(CH_BSLASH);
                    text_q.push_back(CH_LO_A);
                end
                3: begin
                    b = 8'($urandom_range(1, 255));
                    if (b == CH_QUOTE || b == CH_BSLASH) b = CH_UNDER;
                    text_q.push_back(b);
                end
                default: begin
                    b = 8'($urandom_range(32, 126));
                    if (b == CH_QUOTE || b == CH_BSLASH) b = CH_LO_A;
                    text_q.push_back(b);
                end
            endcase
        end
        if (closed) text_q.push_back(CH_QUOTE);
    endfunction

    function automatic void add_token();
        case ($urandom_range(0, 19))
            0, 1, 2: text_q.push_back(CH_LPAREN);
            3, 4, 5: text_q.push_back(CH_RPAREN);
            6, 7, 8, 9, 19: begin
                text_q.push_back(pick(NAME_HEAD));
                repeat ($urandom_range(0, 8)) text_q.push_back(pick(NAME_BODY));
            end
            10, 11, 12, 17, 18: add_number();
            13, 14: add_string(1'b1);
            15: begin
                text_q.push_back(pick("-."));
                text_q.push_back(pick("()x \"-.\n"));
            end
            default: text_q.push_back(8'($urandom_range(1, 255)));
        endcase
        case ($urandom_range(0, 4))
            0: ;
            1: begin
                text_q.push_back(pick(" \t\r\n"));
                text_q.push_back(pick(" \t\r\n"));
            end
            default: text_q.push_back(pick(" \t\r\n"));
        endcase
    endfunction

    function automatic void make_text();
        text_q.delete();
        repeat ($urandom_range(1, 16)) add_token();
        if ($urandom_range(0, 15) == 0) add_string(1'b0);
        text_q.push_back(CH_NUL);
    endfunction

    task automatic send_byte(input logic [7:0] b);
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_byte <= b;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sent_bytes++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    task automatic send_queue();
        foreach (text_q[i]) send_byte(text_q[i]);
    endtask

    initial begin
        int k;
        sb = new();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        gap_pct = 30;
        stall_pct = 30;
        send_text("(a9 -7.5 .3)-x .(\"q\\\"\"");
        send_byte(8'hFF);
        send_text("\n\"u");
        send_byte(CH_NUL);

        while (sent_bytes < 1600) begin
            case ($urandom_range(0, 2))
                0: begin
                    gap_pct = 0;
                    stall_pct = 0;
                end
                1: begin
                    gap_pct = 15;
                    stall_pct = 15;
                end
                default: begin
                    gap_pct = $urandom_range(30, 60);
                    stall_pct = $urandom_range(30, 60);
                end
            endcase
            make_text();
            send_queue();
        end

        gap_pct = 0;
        stall_pct = 0;
        while (sent_bytes < 1850) begin
            make_text();
            send_queue();
        end

        send_text("(x -1.25");
        send_byte(CH_NUL);
        i_in_valid <= 1'b0;

        @(posedge i_clk);
        for (k = 0; k < 4000 && sb.tokens_due.size() > 0; k++) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        sb.leftover();

        $display("Scanned %0d bytes in %0d texts with random idling, then a burst-free stretch.",
                 sb.bytes_in, sb.texts_done);
        $display("Tokens checked: %0d parens, %0d strings, %0d symbols, %0d numbers,",
                 sb.kind_count[1] + sb.kind_count[2], sb.kind_count[3], sb.kind_count[4],
                 sb.kind_count[5]);
        $display("%0d errors, %0d ends.", sb.kind_count[6], sb.kind_count[0]);
        if (sb.errors == 0) begin
            $display("sexpr_token_scanner_top regression: pass");
        end else begin
            $display("sexpr_token_scanner_top regression: fail");
        end
        $finish;
    end

    initial begin
        #12_000_000;
        $display("sexpr_token_scanner_top regression: fail");
        $finish;
    end
endmodule
